// File: rtl/core/ffha_pkg.sv
// ----------------------------------------------------------------------------
// ffha_pkg
// Types and codes shared by the heap allocator modules.
// ----------------------------------------------------------------------------
package ffha_pkg;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BAD_SIZE = 3'd1;
	localparam logic [2:0] ST_NO_FIT   = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_OWNER    = 3'd4;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef struct packed {
		logic        operation;
		logic [14:0] request_bytes;
		logic [11:0] data_address;
		logic [7:0]  requester_id;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [11:0] granted_address;
	} rsp_t;

endpackage

// File: rtl/core/ffha_if.sv
// ----------------------------------------------------------------------------
// ffha_req_if / ffha_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface ffha_req_if;
	logic            valid;
	logic            ready;
	ffha_pkg::req_t  payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface ffha_rsp_if;
	logic            valid;
	logic            ready;
	ffha_pkg::rsp_t  payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/core/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// Walk: S_RD, S_WAIT, S_CHK per region; carve or merge adds further states.
// Throughput: one request at a time; rate follows the region count, since
// the chain is walked one header per read of the header memory.
// Reset: the S_INIT state writes the whole-heap free header at entry 0;
// the block takes no request while in that state.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator #(
	parameter int HEAP_UNITS   = 4096,
	parameter int HEADER_UNITS = 2,
	parameter int UNIT_BYTES   = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [11:0]       cfg_wdata,
	ffha_req_if.sink          req,
	ffha_rsp_if.source        rsp
);
	localparam int AW = (HEAP_UNITS > 1) ? $clog2(HEAP_UNITS) : 1;
	localparam int SW = AW + 1;
	localparam int CW = AW + 2;
	localparam int HW = 1 + SW + 8;
	localparam int UB = $clog2(UNIT_BYTES);
	localparam logic [SW+1:0] HDR = (SW+2)'(HEADER_UNITS);
	localparam logic [SW+1:0] HEAP = (SW+2)'(HEAP_UNITS);
	localparam logic [31:0] MAXB = 32'((HEAP_UNITS - HEADER_UNITS) * UNIT_BYTES);

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_RD, S_WAIT, S_CHK, S_NXRD, S_NXWAIT, S_NXCHK,
		S_WR2, S_PRD, S_PWAIT, S_PCHK, S_OUT
	} state_t;

	state_t state_q;
	logic [11:0] reserve_q;
	ffha_pkg::req_t req_q;
	logic [CW-1:0] count_q, idx_q;
	logic [SW+1:0] at_q, prev_q, units_q, need_q;
	logic [SW-1:0] cur_size_q;
	logic [2:0] status_q;
	logic [11:0] grant_q;
	logic rsp_valid_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [HW-1:0] wdata, rdata;
	logic          rd_free;
	logic [SW-1:0] rd_size;
	logic [7:0]    rd_owner;

	assign rd_free  = rdata[HW-1];
	assign rd_size  = rdata[HW-2 -: SW];
	assign rd_owner = rdata[7:0];

	ffha_hdr_mem #(.AW(AW), .DW(HW)) u_mem (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign req.ready = (state_q == S_IDLE) && !rsp_valid_q;
	assign rsp.valid = rsp_valid_q;
	assign rsp.payload.status = status_q;
	assign rsp.payload.granted_address = grant_q;

	logic [SW+1:0] nxt_at, nh, grown, nx_addr;
	assign nxt_at  = at_q + HDR + (SW+2)'(rd_size);
	assign nh      = at_q + (SW+2)'(rd_size) - units_q;
	assign grown   = (SW+2)'(cur_size_q) + HDR + (SW+2)'(rd_size);
	assign nx_addr = at_q + HDR + (SW+2)'(cur_size_q);

	logic [15:0] rb_units;
	assign rb_units = (16'(req.payload.request_bytes) + 16'(UNIT_BYTES - 1)) >> UB;

	always_comb begin
		we = 1'b0;
		waddr = at_q[AW-1:0];
		wdata = '0;
		raddr = at_q[AW-1:0];
		case (state_q)
			S_INIT: begin
				we = 1'b1;
				waddr = '0;
				wdata = {1'b1, SW'(HEAP_UNITS - HEADER_UNITS), 8'd0};
			end
			S_CHK: begin
				if (req_q.operation == ffha_pkg::OP_ALLOC) begin
					if (rd_free && (SW+2)'(rd_size) >= need_q && nh < HEAP) begin
						we = 1'b1;
						waddr = nh[AW-1:0];
						wdata = {1'b0, units_q[SW-1:0], req_q.requester_id};
					end
				end else if (at_q + HDR == (SW+2)'(req_q.data_address) && !rd_free
						&& rd_owner == req_q.requester_id) begin
					we = 1'b1;
					wdata = {1'b1, rd_size, rd_owner};
				end
			end
			S_NXRD: raddr = nx_addr[AW-1:0];
			S_NXWAIT: raddr = nx_addr[AW-1:0];
			S_WR2: begin
				we = 1'b1;
				wdata = {1'b1, cur_size_q, 8'd0};
			end
			S_PRD: raddr = prev_q[AW-1:0];
			S_PWAIT: raddr = prev_q[AW-1:0];
			S_PCHK: begin
				if (rd_free) begin
					we = 1'b1;
					waddr = prev_q[AW-1:0];
					wdata = {1'b1, SW'(grown), rd_owner};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			reserve_q <= '0;
			count_q <= CW'(1);
			rsp_valid_q <= 1'b0;
			status_q <= ffha_pkg::ST_OK;
			grant_q <= '0;
		end else begin
			if (cfg_we) begin
				reserve_q <= cfg_wdata;
			end
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: state_q <= S_IDLE;
				S_IDLE: begin
					if (req.valid && req.ready) begin
						req_q <= req.payload;
						at_q <= '0;
						prev_q <= '0;
						idx_q <= '0;
						units_q <= (SW+2)'(rb_units);
						need_q <= (SW+2)'(rb_units) + HDR + (SW+2)'(reserve_q);
						grant_q <= '0;
						if (req.payload.operation == ffha_pkg::OP_ALLOC
								&& (req.payload.request_bytes == '0
								|| 32'(req.payload.request_bytes) >= MAXB)) begin
							status_q <= ffha_pkg::ST_BAD_SIZE;
							rsp_valid_q <= 1'b1;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					if (idx_q < count_q && at_q < HEAP) begin
						state_q <= S_WAIT;
					end else begin
						status_q <= (req_q.operation == ffha_pkg::OP_ALLOC)
							? ffha_pkg::ST_NO_FIT : ffha_pkg::ST_NOT_FOUND;
						state_q <= S_OUT;
					end
				end
				S_WAIT: state_q <= S_CHK;
				S_CHK: begin
					if (req_q.operation == ffha_pkg::OP_ALLOC) begin
						if (rd_free && (SW+2)'(rd_size) >= need_q) begin
							if (nh < HEAP) begin
								status_q <= ffha_pkg::ST_OK;
								grant_q <= 12'(nh + HDR);
								count_q <= count_q + CW'(1);
								cur_size_q <= SW'((SW+2)'(rd_size) - units_q - HDR);
								state_q <= S_WR2;
							end else begin
								status_q <= ffha_pkg::ST_NO_FIT;
								state_q <= S_OUT;
							end
						end else begin
							at_q <= nxt_at;
							idx_q <= idx_q + CW'(1);
							state_q <= S_RD;
						end
					end else if (at_q + HDR == (SW+2)'(req_q.data_address)) begin
						cur_size_q <= rd_size;
						if (rd_free) begin
							status_q <= ffha_pkg::ST_NOT_FOUND;
							state_q <= S_OUT;
						end else if (rd_owner != req_q.requester_id) begin
							status_q <= ffha_pkg::ST_OWNER;
							state_q <= S_OUT;
						end else begin
							status_q <= ffha_pkg::ST_OK;
							if (idx_q + CW'(1) < count_q && nxt_at < HEAP) begin
								state_q <= S_NXRD;
							end else begin
								state_q <= (idx_q != '0) ? S_PRD : S_OUT;
							end
						end
					end else begin
						prev_q <= at_q;
						at_q <= nxt_at;
						idx_q <= idx_q + CW'(1);
						state_q <= S_RD;
					end
				end
				S_NXRD: state_q <= S_NXWAIT;
				S_NXWAIT: state_q <= S_NXCHK;
				S_NXCHK: begin
					if (rd_free) begin
						cur_size_q <= SW'(grown);
						count_q <= count_q - CW'(1);
						state_q <= S_WR2;
					end else begin
						state_q <= (idx_q != '0) ? S_PRD : S_OUT;
					end
				end
				S_WR2: begin
					if (req_q.operation == ffha_pkg::OP_FREE && idx_q != '0) begin
						state_q <= S_PRD;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_PRD: state_q <= S_PWAIT;
				S_PWAIT: state_q <= S_PCHK;
				S_PCHK: begin
					if (rd_free) begin
						count_q <= count_q - CW'(1);
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					rsp_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: rtl/core/ffha_hdr_mem.sv
// ----------------------------------------------------------------------------
// ffha_hdr_mem
// Header store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffha_hdr_mem #(
	parameter int AW = 12,
	parameter int DW = 22
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [0:(1<<AW)-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/core/ffha_checker.sv
// ----------------------------------------------------------------------------
// ffha_checker
// Port-level checks on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffha_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input ffha_pkg::rsp_t rsp_payload
);
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
		else $error("result dropped while stalled");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_payload.status <= ffha_pkg::ST_OWNER)
		else $error("bad status code");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_payload.status != ffha_pkg::ST_OK |->
		rsp_payload.granted_address == '0)
		else $error("address on error");
	a_one_at_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second request taken");
endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
	.clk(clk), .arst_n(arst_n),
	.req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.rsp_payload(rsp.payload)
);
